/* src/secp_pkg.sv */
// Shared types and constants for the serial engine command parser.
package secp_pkg;

    localparam logic [7:0] OPC_SET_LOW   = 8'h80;
    localparam logic [7:0] OPC_READ_LOW  = 8'h81;
    localparam logic [7:0] OPC_CLK_DIV   = 8'h86;
    localparam logic [7:0] OPC_DIV5      = 8'h8B;
    localparam logic [7:0] OPC_CLK_BITS  = 8'h8E;
    localparam logic [7:0] OPC_CLK_BYTES = 8'h8F;

    localparam int BIT_SPECIAL  = 7;
    localparam int BIT_DATA_OUT = 4;

    localparam int LEFT_W = 17;

    typedef enum logic [1:0] {
        PH_OPCODE = 2'd0,
        PH_PARAM0 = 2'd1,
        PH_PARAM1 = 2'd2,
        PH_DATA   = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_REPLY   = 3'd1,
        ACT_SETPINS = 3'd2,
        ACT_BITCLK  = 3'd3,
        ACT_BYTECLK = 3'd4,
        ACT_DATA    = 3'd5,
        ACT_UNKNOWN = 3'd6
    } action_t;

    typedef struct packed {
        phase_t              parse_phase;
        logic [7:0]          held_opcode;
        logic [7:0]          first_param;
        logic [LEFT_W-1:0]   bytes_left;
    } parse_state_t;

    // Packed so that action lands in the lowest bits of the output word.
    typedef struct packed {
        logic       reset_drive;
        logic       reset_level_out;
        logic       cs_drive;
        logic       cs_level_out;
        logic [8:0] clock_count;
        logic [7:0] spi_byte;
        logic [7:0] reply_byte;
        action_t    action;
    } result_t;

endpackage

/* src/secp_decode.sv */
// Next-state and result logic for one command byte.
module secp_decode (
    input  secp_pkg::parse_state_t cur,
    input  logic [7:0]             cmd_byte,
    input  logic                   cs_sense,
    input  logic                   cdone_sense,
    input  logic                   creset_sense,
    output secp_pkg::parse_state_t nxt,
    output secp_pkg::result_t      res
);
    import secp_pkg::*;

    logic [LEFT_W-1:0] left_dec;

    assign left_dec = cur.bytes_left - LEFT_W'(1);

    always_comb
    begin
        nxt = cur;
        res = '0;
        res.action = ACT_NONE;
        case (cur.parse_phase)
            PH_OPCODE:
            begin
                nxt.held_opcode = cmd_byte;
                if (cmd_byte[BIT_SPECIAL])
                begin
                    case (cmd_byte)
                        OPC_READ_LOW:
                        begin
                            res.action     = ACT_REPLY;
                            res.reply_byte = {creset_sense, cdone_sense, 1'b0, cs_sense, 4'b0};
                        end
                        OPC_DIV5: ;
                        OPC_SET_LOW, OPC_CLK_DIV, OPC_CLK_BITS, OPC_CLK_BYTES:
                            nxt.parse_phase = PH_PARAM0;
                        default:
                            res.action = ACT_UNKNOWN;
                    endcase
                end
                else if (cmd_byte[BIT_DATA_OUT])
                begin
                    nxt.parse_phase = PH_PARAM0;
                end
            end
            PH_PARAM0:
            begin
                nxt.parse_phase = PH_OPCODE;
                if (cur.held_opcode[BIT_SPECIAL])
                begin
                    case (cur.held_opcode)
                        OPC_SET_LOW, OPC_CLK_BYTES:
                        begin
                            nxt.first_param = cmd_byte;
                            nxt.parse_phase = PH_PARAM1;
                        end
                        OPC_CLK_DIV:
                            nxt.parse_phase = PH_PARAM1;
                        OPC_CLK_BITS:
                        begin
                            nxt.first_param   = cmd_byte;
                            res.action        = ACT_BITCLK;
                            res.clock_count   = {1'b0, cmd_byte} + 9'd1;
                        end
                        default: ;
                    endcase
                end
                else if (cur.held_opcode[BIT_DATA_OUT])
                begin
                    nxt.first_param = cmd_byte;
                    nxt.parse_phase = PH_PARAM1;
                end
            end
            PH_PARAM1:
            begin
                nxt.parse_phase = PH_OPCODE;
                if (cur.held_opcode[BIT_SPECIAL])
                begin
                    case (cur.held_opcode)
                        OPC_SET_LOW:
                        begin
                            res.action          = ACT_SETPINS;
                            res.cs_level_out    = cur.first_param[4];
                            res.cs_drive        = cmd_byte[4];
                            res.reset_level_out = cur.first_param[7];
                            res.reset_drive     = cmd_byte[7];
                        end
                        OPC_CLK_BYTES:
                        begin
                            res.action      = ACT_BYTECLK;
                            res.clock_count = {1'b0, cur.first_param} + 9'd1;
                        end
                        default: ;
                    endcase
                end
                else if (cur.held_opcode[BIT_DATA_OUT])
                begin
                    // 17 bits so a length of 0xFFFF yields 65536 bytes
                    nxt.bytes_left  = {1'b0, cmd_byte, cur.first_param} + LEFT_W'(1);
                    nxt.parse_phase = PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (!cur.held_opcode[BIT_DATA_OUT] || cur.bytes_left == '0)
                begin
                    nxt.bytes_left  = '0;
                    nxt.parse_phase = PH_OPCODE;
                end
                else
                begin
                    res.action     = ACT_DATA;
                    res.spi_byte   = cmd_byte;
                    nxt.bytes_left = left_dec;
                    if (left_dec == '0)
                        nxt.parse_phase = PH_OPCODE;
                end
            end
            default:
                nxt.parse_phase = PH_OPCODE;
        endcase
    end

endmodule

/* src/serial_engine_command_parser.sv */
// Top level: serial engine command parser with registered result transfer.
//
//  channel   dir  bits  contents
//  s_*       in   16    cmd_byte, cs_sense, cdone_sense, creset_sense
//  m_*       out  32    action, reply_byte, spi_byte, clock_count, pin levels/drives
//
// Each accepted byte yields exactly one result in the next cycle; one byte per cycle
// is sustained while m_tready is high, set by the single decode-to-m_tdata register.
// Reset puts the parser in the opcode phase with all counters cleared.
// While m_tvalid is high and m_tready low, s_tready drops and the result holds.
module serial_engine_command_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] cmd_byte, [8] cs_sense, [9] cdone_sense,
                                   // [10] creset_sense, [15:11] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [2:0] action, [10:3] reply_byte, [18:11] spi_byte,
                                   // [27:19] clock_count, [28] cs_level_out,
                                   // [29] cs_drive, [30] reset_level_out, [31] reset_drive
);
    import secp_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      result_reg;
    result_t      result_next;
    logic         valid_reg;
    logic         accept;

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = result_reg;

    secp_decode u_decode (
        .cur          (state_reg),
        .cmd_byte     (s_tdata[7:0]),
        .cs_sense     (s_tdata[8]),
        .cdone_sense  (s_tdata[9]),
        .creset_sense (s_tdata[10]),
        .nxt          (state_next),
        .res          (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{parse_phase: PH_OPCODE, held_opcode: '0,
                           first_param: '0, bytes_left: '0};
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                state_reg <= state_next;
            if (accept)
                valid_reg <= 1'b1;
            else if (m_tready)
                valid_reg <= 1'b0;
        end
    end

    // payload register, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.parse_phase == PH_DATA |-> state_reg.bytes_left != '0)
        else $error("data phase with empty byte count");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.parse_phase == PH_PARAM1 |->
            (state_reg.held_opcode == OPC_SET_LOW || state_reg.held_opcode == OPC_CLK_DIV ||
             state_reg.held_opcode == OPC_CLK_BYTES ||
             (!state_reg.held_opcode[BIT_SPECIAL] && state_reg.held_opcode[BIT_DATA_OUT])))
        else $error("second parameter phase with wrong opcode");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (result_reg.clock_count != '0) |->
            (result_reg.action == ACT_BITCLK || result_reg.action == ACT_BYTECLK))
        else $error("clock count set for non-clock action");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && state_reg.parse_phase == PH_DATA |=> m_tvalid &&
            (result_reg.action == ACT_DATA || result_reg.action == ACT_NONE))
        else $error("data phase produced wrong action");

endmodule

/* test/tb.sv */
// Self-checking stream testbench for the serial engine command parser.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import secp_pkg::*;

    localparam int IDLE_PCT   = 16;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_LEN   = 400;
    localparam int RAND_ITEMS = 580;
    localparam int FULL_TAIL  = 40;

    // One command-stream byte with the pin levels sampled alongside it.
    typedef struct packed {
        logic       creset_sense;
        logic       cdone_sense;
        logic       cs_sense;
        logic [7:0] cmd_byte;
    } cmd_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // [7:0] cmd_byte, [8] cs_sense, [9] cdone_sense,
                                 // [10] creset_sense, [15:11] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // [2:0] action, [10:3] reply_byte, [18:11] spi_byte,
                                 // [27:19] clock_count, [28] cs_level_out,
                                 // [29] cs_drive, [30] reset_level_out, [31] reset_drive

    cmd_item_t cmd_stream[$];
    result_t   due_actions[$];

    // Parser state as tracked by the predictor.
    phase_t            phase_m;
    logic [7:0]        op_latch;
    logic [7:0]        len_lo;
    logic [LEFT_W-1:0] payload_left;

    int unsigned bytes_sent;
    int unsigned results_seen;
    int unsigned errors;
    int unsigned hold_left;
    logic        hold_done;
    int unsigned stall_cycles;

    wire steady = (bytes_sent >= 120) && (bytes_sent < 260);

    serial_engine_command_parser u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t parse_cmd_byte(input cmd_item_t it);
        result_t    r;
        logic [7:0] c;
        r = '0;
        r.action = ACT_NONE;
        c = it.cmd_byte;
        case (phase_m)
            PH_OPCODE:
            begin
                op_latch = c;
                if (c[BIT_SPECIAL])
                begin
                    case (c)
                        OPC_READ_LOW:
                        begin
                            r.action = ACT_REPLY;
                            r.reply_byte = {it.creset_sense, it.cdone_sense, 1'b0,
                                            it.cs_sense, 4'b0000};
                        end
                        OPC_DIV5:
                            r.action = ACT_NONE;
                        OPC_SET_LOW, OPC_CLK_DIV, OPC_CLK_BITS, OPC_CLK_BYTES:
                            phase_m = PH_PARAM0;
                        default:
                            r.action = ACT_UNKNOWN;
                    endcase
                end
                else if (c[BIT_DATA_OUT])
                    phase_m = PH_PARAM0;
            end
            PH_PARAM0:
            begin
                if (op_latch[BIT_SPECIAL])
                begin
                    case (op_latch)
                        OPC_SET_LOW, OPC_CLK_BYTES:
                        begin
                            len_lo = c;
                            phase_m = PH_PARAM1;
                        end
                        OPC_CLK_DIV:
                            phase_m = PH_PARAM1;
                        OPC_CLK_BITS:
                        begin
                            len_lo = c;
                            r.action = ACT_BITCLK;
                            r.clock_count = {1'b0, c} + 9'd1;
                            phase_m = PH_OPCODE;
                        end
                        default:
                            phase_m = PH_OPCODE;
                    endcase
                end
                else if (op_latch[BIT_DATA_OUT])
                begin
                    len_lo = c;
                    phase_m = PH_PARAM1;
                end
                else
                    phase_m = PH_OPCODE;
            end
            PH_PARAM1:
            begin
                if (op_latch[BIT_SPECIAL])
                begin
                    if (op_latch == OPC_SET_LOW)
                    begin
                        r.action = ACT_SETPINS;
                        r.cs_level_out = len_lo[4];
                        r.cs_drive = c[4];
                        r.reset_level_out = len_lo[7];
                        r.reset_drive = c[7];
                    end
                    else if (op_latch == OPC_CLK_BYTES)
                    begin
                        r.action = ACT_BYTECLK;
                        r.clock_count = {1'b0, len_lo} + 9'd1;
                    end
                    phase_m = PH_OPCODE;
                end
                else if (op_latch[BIT_DATA_OUT])
                begin
                    payload_left = {1'b0, c, len_lo} + 17'd1;
                    phase_m = PH_DATA;
                end
                else
                    phase_m = PH_OPCODE;
            end
            default:
            begin
                if (!op_latch[BIT_DATA_OUT] || payload_left == '0)
                begin
                    payload_left = '0;
                    phase_m = PH_OPCODE;
                end
                else
                begin
                    r.action = ACT_DATA;
                    r.spi_byte = c;
                    payload_left = payload_left - 17'd1;
                    if (payload_left == '0)
                        phase_m = PH_OPCODE;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
                 results_seen, what, got, want);
    endtask

    // pins: {creset, cdone, cs}
    task automatic add_byte(input logic [7:0] b, input logic [2:0] pins);
        cmd_item_t it;
        it.cmd_byte = b;
        {it.creset_sense, it.cdone_sense, it.cs_sense} = pins;
        cmd_stream.push_back(it);
    endtask

    task automatic add_write(input logic [7:0] op, input int unsigned len);
        int unsigned i;
        add_byte(op, 3'($urandom_range(0, 7)));
        add_byte(len[7:0], 3'($urandom_range(0, 7)));
        add_byte(len[15:8], 3'($urandom_range(0, 7)));
        for (i = 0; i <= len; i++)
            add_byte(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
    endtask

    // Driver: present the next queued byte, predict its result on each transfer.
    always @(posedge clk or negedge rst_n)
    begin : drive_blk
        logic fire;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            bytes_sent <= 0;
        end
        else
        begin
            fire = s_tvalid && s_tready;
            if (fire)
            begin
                due_actions.push_back(parse_cmd_byte(cmd_stream[0]));
                void'(cmd_stream.pop_front());
                bytes_sent <= bytes_sent + 1;
            end
            // Hold valid and data until the transfer completes.
            if (fire || !s_tvalid)
            begin
                if (cmd_stream.size() != 0 &&
                    (steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {5'b00000, cmd_stream[0]};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off so the output register fills and stalls the input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && bytes_sent >= 300)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: compare each result transfer with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : watch_blk
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            results_seen <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (due_actions.size() == 0)
                    report_mismatch("result with nothing pending", m_tdata, 0);
                else
                begin
                    want = due_actions.pop_front();
                    if (got.action != want.action)
                        report_mismatch("action", got.action, want.action);
                    if (got.reply_byte != want.reply_byte)
                        report_mismatch("reply_byte", got.reply_byte, want.reply_byte);
                    if (got.spi_byte != want.spi_byte)
                        report_mismatch("spi_byte", got.spi_byte, want.spi_byte);
                    if (got.clock_count != want.clock_count)
                        report_mismatch("clock_count", got.clock_count, want.clock_count);
                    if (got.cs_level_out != want.cs_level_out)
                        report_mismatch("cs_level_out", got.cs_level_out,
                                        want.cs_level_out);
                    if (got.cs_drive != want.cs_drive)
                        report_mismatch("cs_drive", got.cs_drive, want.cs_drive);
                    if (got.reset_level_out != want.reset_level_out)
                        report_mismatch("reset_level_out", got.reset_level_out,
                                        want.reset_level_out);
                    if (got.reset_drive != want.reset_drive)
                        report_mismatch("reset_drive", got.reset_drive, want.reset_drive);
                end
                results_seen <= results_seen + 1;
            end
            m_tready <= (hold_left == 0) && (steady || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
        else
            stall_cycles <= 0;
    end

    initial
    begin
        int unsigned base;
        int unsigned kind;
        int unsigned len;
        logic [31:0] rnd;
        logic [7:0]  b;

        errors = 0;
        phase_m = PH_OPCODE;
        op_latch = '0;
        len_lo = '0;
        payload_left = '0;

        // Directed: pin reply patterns, every special opcode, field extremes.
        add_byte(OPC_READ_LOW, 3'b000);
        add_byte(OPC_READ_LOW, 3'b111);
        add_byte(OPC_READ_LOW, 3'b101);
        add_byte(OPC_SET_LOW, 3'b010);
        add_byte(8'h90, 3'b000);
        add_byte(8'h6F, 3'b111);
        add_byte(OPC_SET_LOW, 3'b001);
        add_byte(8'h6F, 3'b100);
        add_byte(8'h90, 3'b011);
        add_byte(OPC_CLK_DIV, 3'b000);
        add_byte(8'hFF, 3'b000);
        add_byte(8'hFF, 3'b000);
        add_byte(OPC_DIV5, 3'b111);
        add_byte(OPC_CLK_BITS, 3'b000);
        add_byte(8'h00, 3'b000);
        add_byte(OPC_CLK_BITS, 3'b110);
        add_byte(8'hFF, 3'b110);
        add_byte(OPC_CLK_BYTES, 3'b000);
        add_byte(8'hFF, 3'b000);
        add_byte(8'h00, 3'b000);
        // Unknown special opcodes, data opcodes lacking the data-out bit, then a one-byte write.
        add_byte(8'h82, 3'b000);
        add_byte(8'hFF, 3'b111);
        add_byte(8'h00, 3'b000);
        add_byte(8'h6F, 3'b111);
        add_write(8'h10, 0);

        base = cmd_stream.size();
        while (cmd_stream.size() < base + RAND_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            rnd = $urandom;
            if (kind < 10)
                add_byte(OPC_READ_LOW, rnd[10:8]);
            else if (kind < 20)
            begin
                add_byte(OPC_SET_LOW, rnd[10:8]);
                add_byte(rnd[7:0], rnd[13:11]);
                add_byte(rnd[23:16], rnd[26:24]);
            end
            else if (kind < 25)
            begin
                add_byte(OPC_CLK_DIV, rnd[10:8]);
                add_byte(rnd[7:0], rnd[13:11]);
                add_byte(rnd[23:16], rnd[26:24]);
            end
            else if (kind < 30)
                add_byte(OPC_DIV5, rnd[10:8]);
            else if (kind < 40)
            begin
                add_byte(OPC_CLK_BITS, rnd[10:8]);
                add_byte(rnd[7:0], rnd[13:11]);
            end
            else if (kind < 50)
            begin
                add_byte(OPC_CLK_BYTES, rnd[10:8]);
                add_byte(rnd[7:0], rnd[13:11]);
                add_byte(rnd[23:16], rnd[26:24]);
            end
            else if (kind < 75)
            begin
                // Keep payloads short; a few reach past one length byte.
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(8, 300);
                else
                    len = $urandom_range(0, 7);
                add_write({1'b0, rnd[6:5], 1'b1, rnd[3:0]}, len);
            end
            else if (kind < 80)
                add_byte({1'b0, rnd[6:5], 1'b0, rnd[3:0]}, rnd[10:8]);
            else if (kind < 85)
            begin
                do
                begin
                    rnd = $urandom;
                    b = {1'b1, rnd[6:0]};
                end
                while (b == OPC_SET_LOW || b == OPC_READ_LOW || b == OPC_CLK_DIV ||
                       b == OPC_DIV5 || b == OPC_CLK_BITS || b == OPC_CLK_BYTES);
                add_byte(b, rnd[10:8]);
            end
            else if (kind < 93)
            begin
                // Noise byte; never a data-out opcode so payloads stay bounded.
                b = rnd[7:0];
                if (!b[7])
                    b[4] = 1'b0;
                add_byte(b, rnd[10:8]);
            end
            else
            begin
                // Truncated special command: the next opcode lands as a parameter.
                case (rnd[17:16])
                    2'd0:
                        add_byte(OPC_CLK_DIV, rnd[10:8]);
                    2'd1:
                    begin
                        add_byte(OPC_CLK_BYTES, rnd[10:8]);
                        add_byte(rnd[7:0], rnd[13:11]);
                    end
                    default:
                    begin
                        add_byte(OPC_SET_LOW, rnd[10:8]);
                        add_byte(rnd[7:0], rnd[13:11]);
                    end
                endcase
            end
        end

        // Full length: 0xFFFF must not wrap to an empty count, so every byte
        // after the header is payload; end the run partway into it.
        rnd = $urandom;
        add_byte({1'b0, rnd[6:5], 1'b1, rnd[3:0]}, rnd[10:8]);
        add_byte(8'hFF, rnd[13:11]);
        add_byte(8'hFF, rnd[16:14]);
        repeat (FULL_TAIL)
            add_byte(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_stream.size() != 0 || s_tvalid || due_actions.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
